### hdl/slseq_pkg.sv
// Package with the shared types and constants of the status LED sequencer.
`default_nettype none
package slseq_pkg;

  typedef enum logic [1:0] {
    PM_CHARGING    = 2'd0,
    PM_CHARGED     = 2'd1,
    PM_DISCHARGING = 2'd2,
    PM_CRITICAL    = 2'd3
  } power_mode_t;

  typedef enum logic [1:0] {
    LK_UNPAIRED  = 2'd0,
    LK_PAIRING   = 2'd1,
    LK_CONNECTED = 2'd2
  } link_mode_t;

  // Event codes carried in the func field.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_POWER  = 3'd1;
  localparam logic [2:0] FUNC_BT     = 3'd2;
  localparam logic [2:0] FUNC_BUTTON = 3'd3;
  localparam logic [2:0] FUNC_PACKET = 3'd4;

  // Link codes carried in the link_state field.
  localparam logic [1:0] LINK_DISC = 2'd0;
  localparam logic [1:0] LINK_PAIR = 2'd1;
  localparam logic [1:0] LINK_CONN = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_BT_EN     = 3'd0;
  localparam logic [2:0] REG_HB_DIS    = 3'd1;
  localparam logic [2:0] REG_HB_DED    = 3'd2;
  localparam logic [2:0] REG_CHG_BLINK = 3'd3;
  localparam logic [2:0] REG_RADIO_MS  = 3'd4;

  // Timing constants in milliseconds.
  localparam logic [31:0] FAST_BLINK_PERIOD = 32'd30000;
  localparam logic [31:0] FAST_BLINK_LEN    = 32'd2000;
  localparam logic [31:0] PAIRING_TIMEOUT   = 32'd30000;
  localparam logic [31:0] BAR_SHOW_TIME     = 32'd10000;
  localparam logic [15:0] IV_DEFAULT        = 16'd1000;
  localparam logic [15:0] IV_FAST           = 16'd250;
  localparam logic [15:0] IV_BEAT_ON        = 16'd1;
  localparam logic [15:0] IV_BEAT_OFF       = 16'd999;
  localparam logic [15:0] RADIO_MS_RESET    = 16'd100;

  // Battery thresholds in percent.
  localparam logic [6:0] PCT_CRITICAL = 7'd5;
  localparam logic [6:0] PCT_FULL     = 7'd100;
  localparam logic [6:0] PCT_LVL1     = 7'd25;
  localparam logic [6:0] PCT_LVL2     = 7'd50;
  localparam logic [6:0] PCT_LVL3     = 7'd75;

endpackage
`default_nettype wire

### hdl/slseq_in_if.sv
// Input channel interface of the status LED sequencer.
`default_nettype none
interface slseq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] now_ms;
  logic        has_usb;
  logic        is_charging;
  logic [6:0]  battery_percent;
  logic [1:0]  link_state;

  modport source (
    output valid, func, now_ms, has_usb, is_charging, battery_percent, link_state,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, has_usb, is_charging, battery_percent, link_state,
    output ready
  );
endinterface
`default_nettype wire

### hdl/slseq_out_if.sv
// Result channel interface of the status LED sequencer.
`default_nettype none
interface slseq_out_if;
  logic        valid;
  logic        ready;
  logic        charge_led;
  logic        pairing_led;
  logic        heartbeat_led;
  logic [3:0]  battery_bar;
  logic        radio_led;
  logic [1:0]  power_class;
  logic [15:0] next_interval_ms;

  modport source (
    output valid, charge_led, pairing_led, heartbeat_led, battery_bar, radio_led,
           power_class, next_interval_ms,
    input  ready
  );
  modport sink (
    input  valid, charge_led, pairing_led, heartbeat_led, battery_bar, radio_led,
           power_class, next_interval_ms,
    output ready
  );
endinterface
`default_nettype wire

### hdl/status_led_sequencer_unit.sv
// Top level of the status LED sequencer: event register, update logic and result register.
`default_nettype none
// The status LED sequencer takes one event word per cycle while its result side is
// not stalled (tick, power report, Bluetooth report, button press or received
// packet, each stamped with a wrapping millisecond time) and returns exactly one
// result word per event: the current charge, pairing, heartbeat and radio LED
// states, the battery bar, the power class and the delay to the next tick. An
// accepted word sits in an input register while the update logic (a handful of
// 32-bit modulo time differences and compares) computes the new LED state, and the
// result is written to the output register once that register is free or being
// emptied. The sustained rate is one word per cycle while the receiver takes every
// result. While a finished result waits on a stalled receiver, the input side takes
// one more word into an empty input register and then stops; once the result is
// taken, both registers move on in the same cycle. Configuration writes on the cfg_
// port are taken at once and must only happen while no event is in flight. Time
// comparisons use now_ms minus the stored mark modulo 2^32, so a mark that lies in
// the future counts as long past.
module status_led_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  slseq_in_if.sink         in_word,
  slseq_out_if.source      out_word
);

  // Configuration registers.
  logic        bt_en_r;
  logic        hb_dis_r;
  logic        hb_ded_r;
  logic        chg_blink_r;
  logic [15:0] radio_ms_r;

  // Input register stage.
  logic        in_v_r;
  logic [2:0]  func_r;
  logic [31:0] now_r;
  logic        usb_r;
  logic        chg_r;
  logic [6:0]  pct_r;
  logic [1:0]  link_r;

  // Sequencer state.
  slseq_pkg::power_mode_t pm_r, pm_nxt;
  slseq_pkg::link_mode_t  lk_r, lk_nxt;
  logic [31:0] pair_since_r, pair_since_nxt;
  logic [31:0] fb_since_r, fb_since_nxt;
  logic        ifb_r, ifb_nxt;
  logic        cl_r, cl_nxt;
  logic        pl_r, pl_nxt;
  logic        hl_r, hl_nxt;
  logic        sp_r, sp_nxt;
  logic [31:0] btn_since_r, btn_since_nxt;
  logic        rl_r, rl_nxt;
  logic [31:0] radio_since_r, radio_since_nxt;
  logic [6:0]  last_pct_r, last_pct_nxt;
  logic [3:0]  bar_r, bar_nxt;
  logic [15:0] iv_nxt;

  // Result register.
  logic        out_v_r;
  logic [15:0] out_iv_r;

  // Working values of the update logic.
  logic [6:0]  pct_sat;
  logic [31:0] d_fb;
  logic [31:0] d_pair;
  logic [31:0] d_btn;
  logic [31:0] el_radio;
  logic [31:0] radio_ms_ext;
  logic [31:0] radio_left;
  logic        fb_start;
  logic        beat_ok;
  logic        adv;
  logic        fire;

  // The stage moves on whenever the result register is free or being emptied.
  assign adv           = !out_v_r || out_word.ready;
  assign fire          = in_v_r && adv;
  assign in_word.ready = !in_v_r || adv;

  assign pct_sat      = (pct_r > slseq_pkg::PCT_FULL) ? slseq_pkg::PCT_FULL : pct_r;
  assign d_fb         = now_r - fb_since_r;
  assign d_pair       = now_r - pair_since_r;
  assign d_btn        = now_r - btn_since_r;
  assign el_radio     = now_r - radio_since_r;
  assign radio_ms_ext = {16'd0, radio_ms_r};
  assign radio_left   = radio_ms_ext - el_radio;

  // Event update. The tick path follows the order in which its rules apply: power
  // mode first, then heartbeat, pairing LED, battery bar and radio flash.
  always_comb begin
    pm_nxt          = pm_r;
    lk_nxt          = lk_r;
    pair_since_nxt  = pair_since_r;
    fb_since_nxt    = fb_since_r;
    ifb_nxt         = ifb_r;
    cl_nxt          = cl_r;
    pl_nxt          = pl_r;
    hl_nxt          = hl_r;
    sp_nxt          = sp_r;
    btn_since_nxt   = btn_since_r;
    rl_nxt          = rl_r;
    radio_since_nxt = radio_since_r;
    last_pct_nxt    = last_pct_r;
    bar_nxt         = bar_r;
    iv_nxt          = 16'd0;
    fb_start        = 1'b0;
    beat_ok         = 1'b0;

    case (func_r)
      slseq_pkg::FUNC_TICK: begin
        iv_nxt = slseq_pkg::IV_DEFAULT;

        case (pm_r)
          slseq_pkg::PM_CHARGING: begin
            if (!chg_blink_r) cl_nxt = !cl_r;
          end
          slseq_pkg::PM_CHARGED: begin
            cl_nxt = 1'b1;
          end
          slseq_pkg::PM_CRITICAL: begin
            // A new fast blink burst starts once the last one is a period old.
            fb_start = (d_fb > slseq_pkg::FAST_BLINK_PERIOD) && !ifb_r;
            if (fb_start) begin
              ifb_nxt      = 1'b1;
              fb_since_nxt = now_r;
            end
            if (ifb_nxt) begin
              pl_nxt = 1'b0;
              cl_nxt = !cl_r;
              iv_nxt = slseq_pkg::IV_FAST;
              // A burst that just started has zero elapsed time.
              if (!fb_start && (d_fb > slseq_pkg::FAST_BLINK_LEN)) begin
                ifb_nxt = 1'b0;
                cl_nxt  = 1'b0;
              end
            end
          end
          default: ;
        endcase

        beat_ok = (pm_r != slseq_pkg::PM_CHARGING) && (pm_r != slseq_pkg::PM_CHARGED) &&
                  !ifb_nxt && !hb_dis_r;
        if (hb_ded_r) begin
          if (beat_ok) begin
            hl_nxt = !hl_r;
            iv_nxt = hl_nxt ? slseq_pkg::IV_BEAT_ON : slseq_pkg::IV_BEAT_OFF;
          end else begin
            hl_nxt = 1'b0;
          end
        end else begin
          hl_nxt = 1'b0;
          if (beat_ok) begin
            cl_nxt = !cl_nxt;
            iv_nxt = cl_nxt ? slseq_pkg::IV_BEAT_ON : slseq_pkg::IV_BEAT_OFF;
          end
        end

        if (!bt_en_r || (d_pair > slseq_pkg::PAIRING_TIMEOUT) || ifb_nxt) begin
          pl_nxt = 1'b0;
        end else begin
          case (lk_r)
            slseq_pkg::LK_UNPAIRED: begin
              // Slow blink: toggle on every second tick.
              if (sp_r) begin
                pl_nxt = !pl_nxt;
                sp_nxt = 1'b0;
              end else begin
                sp_nxt = 1'b1;
              end
            end
            slseq_pkg::LK_PAIRING: pl_nxt = !pl_nxt;
            default:               pl_nxt = 1'b1;
          endcase
        end

        if (hb_dis_r) cl_nxt = 1'b0;

        bar_nxt = 4'd0;
        if ((d_btn < slseq_pkg::BAR_SHOW_TIME) || cl_nxt) begin
          bar_nxt[0] = 1'b1;
          bar_nxt[1] = last_pct_r >= slseq_pkg::PCT_LVL1;
          bar_nxt[2] = last_pct_r >= slseq_pkg::PCT_LVL2;
          bar_nxt[3] = last_pct_r >= slseq_pkg::PCT_LVL3;
        end

        if (rl_r) begin
          if (el_radio >= radio_ms_ext) begin
            rl_nxt = 1'b0;
          end else if ({16'd0, iv_nxt} > radio_left) begin
            iv_nxt = radio_left[15:0];
          end
        end
      end

      slseq_pkg::FUNC_POWER: begin
        last_pct_nxt = pct_sat;
        if (usb_r || chg_r) begin
          pm_nxt = (pct_sat >= slseq_pkg::PCT_FULL) ? slseq_pkg::PM_CHARGED
                                                    : slseq_pkg::PM_CHARGING;
        end else begin
          pm_nxt = (pct_sat > slseq_pkg::PCT_CRITICAL) ? slseq_pkg::PM_DISCHARGING
                                                       : slseq_pkg::PM_CRITICAL;
        end
      end

      slseq_pkg::FUNC_BT: begin
        case (link_r)
          slseq_pkg::LINK_DISC: begin
            lk_nxt         = slseq_pkg::LK_UNPAIRED;
            pair_since_nxt = now_r;
          end
          slseq_pkg::LINK_PAIR: begin
            lk_nxt         = slseq_pkg::LK_PAIRING;
            pair_since_nxt = now_r;
          end
          slseq_pkg::LINK_CONN: begin
            // For a connect report, only a change of state restarts the pairing LED timeout.
            if (lk_r != slseq_pkg::LK_CONNECTED) begin
              lk_nxt         = slseq_pkg::LK_CONNECTED;
              pair_since_nxt = now_r;
            end
          end
          default: ;
        endcase
      end

      slseq_pkg::FUNC_BUTTON: begin
        btn_since_nxt = now_r;
      end

      slseq_pkg::FUNC_PACKET: begin
        rl_nxt          = 1'b1;
        radio_since_nxt = now_r;
        iv_nxt          = radio_ms_r;
      end

      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_en_r     <= 1'b1;
      hb_dis_r    <= 1'b0;
      hb_ded_r    <= 1'b0;
      chg_blink_r <= 1'b0;
      radio_ms_r  <= slseq_pkg::RADIO_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        slseq_pkg::REG_BT_EN:     bt_en_r     <= cfg_wdata[0];
        slseq_pkg::REG_HB_DIS:    hb_dis_r    <= cfg_wdata[0];
        slseq_pkg::REG_HB_DED:    hb_ded_r    <= cfg_wdata[0];
        slseq_pkg::REG_CHG_BLINK: chg_blink_r <= cfg_wdata[0];
        slseq_pkg::REG_RADIO_MS:  radio_ms_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: loads whenever the stage is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_word.ready) begin
      in_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      func_r <= in_word.func;
      now_r  <= in_word.now_ms;
      usb_r  <= in_word.has_usb;
      chg_r  <= in_word.is_charging;
      pct_r  <= in_word.battery_percent;
      link_r <= in_word.link_state;
    end
  end

  // Sequencer state, written when a word is processed, and result valid flag, written whenever the stage moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r          <= slseq_pkg::PM_DISCHARGING;
      lk_r          <= slseq_pkg::LK_UNPAIRED;
      pair_since_r  <= 32'd0;
      fb_since_r    <= 32'd0;
      ifb_r         <= 1'b0;
      cl_r          <= 1'b0;
      pl_r          <= 1'b0;
      hl_r          <= 1'b0;
      sp_r          <= 1'b0;
      btn_since_r   <= 32'd0;
      rl_r          <= 1'b0;
      radio_since_r <= 32'd0;
      last_pct_r    <= 7'd0;
      bar_r         <= 4'd0;
      out_v_r       <= 1'b0;
    end else begin
      if (fire) begin
        pm_r          <= pm_nxt;
        lk_r          <= lk_nxt;
        pair_since_r  <= pair_since_nxt;
        fb_since_r    <= fb_since_nxt;
        ifb_r         <= ifb_nxt;
        cl_r          <= cl_nxt;
        pl_r          <= pl_nxt;
        hl_r          <= hl_nxt;
        sp_r          <= sp_nxt;
        btn_since_r   <= btn_since_nxt;
        rl_r          <= rl_nxt;
        radio_since_r <= radio_since_nxt;
        last_pct_r    <= last_pct_nxt;
        bar_r         <= bar_nxt;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_iv_r <= iv_nxt;
    end
  end

  // The LED fields show the state registers, which change only together with a
  // new result, so they always match the word in the result register.
  assign out_word.valid            = out_v_r;
  assign out_word.charge_led       = cl_r;
  assign out_word.pairing_led      = pl_r;
  assign out_word.heartbeat_led    = hl_r;
  assign out_word.battery_bar      = bar_r;
  assign out_word.radio_led        = rl_r;
  assign out_word.power_class      = pm_r;
  assign out_word.next_interval_ms = out_iv_r;

endmodule
`default_nettype wire
